// ===== rtl/xdrt_pkg.sv =====
// Shared types and constants of the XOR-distance routing table.
// Used by every module of the block; depends on nothing.
package xdrt_pkg;

   // Identifier, endpoint and stored entry widths
   localparam int ID_W    = 160;
   localparam int EP_W    = 48;
   localparam int ENTRY_W = ID_W + EP_W;

   // Default table geometry
   localparam int BUCKET_SIZE_DEF = 8;
   localparam int MAX_BUCKETS_DEF = 160;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ID0 = 2'd0,
      CSR_OWN_ID1 = 2'd1,
      CSR_OWN_ID2 = 2'd2
   } csr_index_type;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_REFRESHED   = 3'd0,
      KIND_APPENDED    = 3'd1,
      KIND_KEPT        = 3'd2,
      KIND_REPLACED    = 3'd3,
      KIND_CLOSEST     = 3'd4,
      KIND_NO_ENTRIES  = 3'd5
   } result_kind_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FILL_RD,
      ST_FILL_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_SAVE_WR,
      ST_INS_DONE,
      ST_Q_FILL_RD,
      ST_Q_FILL_WAIT,
      ST_Q_SCAN,
      ST_Q_DRAIN,
      ST_EMIT
   } state_type;

   // Control of the closest-entry selector
   typedef struct packed {
      logic clear;
      logic push;
   } topk_ctl_type;

endpackage

// ===== rtl/xdrt_req_if.sv =====
// Request channel of the routing table: valid/ready plus one request item.
// Depends on nothing.
interface xdrt_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [63:0] id_word0;
   logic [63:0] id_word1;
   logic [31:0] id_word2;
   logic [31:0] ip_addr;
   logic [15:0] port_num;
   logic        oldest_alive;

   modport source (
      output valid, operation, id_word0, id_word1, id_word2, ip_addr, port_num,
             oldest_alive,
      input  ready
   );
   modport sink (
      input  valid, operation, id_word0, id_word1, id_word2, ip_addr, port_num,
             oldest_alive,
      output ready
   );
endinterface

// ===== rtl/xdrt_rsp_if.sv =====
// Response channel of the routing table: valid/ready plus one result item.
// Depends on nothing.
interface xdrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [7:0]  bucket_num;
   logic [63:0] out_id_word0;
   logic [63:0] out_id_word1;
   logic [31:0] out_id_word2;
   logic [31:0] out_ip;
   logic [15:0] out_port;
   logic        last_flag;

   modport source (
      output valid, result_kind, bucket_num, out_id_word0, out_id_word1,
             out_id_word2, out_ip, out_port, last_flag,
      input  ready
   );
   modport sink (
      input  valid, result_kind, bucket_num, out_id_word0, out_id_word1,
             out_id_word2, out_ip, out_port, last_flag,
      output ready
   );
endinterface

// ===== rtl/xdrt_entry_mem.sv =====
// Entry store: one synchronous memory of identifier plus endpoint entries.
// One write and one registered read per cycle; depends on xdrt_pkg.
module xdrt_entry_mem #(
   parameter int DEPTH = 1280,
   parameter int AW    = 11
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [xdrt_pkg::ENTRY_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [xdrt_pkg::ENTRY_W-1:0] wr_data
);

   logic [xdrt_pkg::ENTRY_W-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/xdrt_fill_tbl.sv =====
// Bucket fill table: one memory of fill counts with a valid bit per bucket,
// so a bucket never written reads as empty. Depends on xdrt_pkg.
module xdrt_fill_tbl #(
   parameter int MAX_BUCKETS = xdrt_pkg::MAX_BUCKETS_DEF,
   parameter int BUCKET_SIZE = xdrt_pkg::BUCKET_SIZE_DEF,
   localparam int BIW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
   localparam int FW  = $clog2(BUCKET_SIZE + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           rd_en,
   input  logic [BIW-1:0] rd_addr,
   output logic [FW-1:0]  rd_data,
   input  logic           wr_en,
   input  logic [BIW-1:0] wr_addr,
   input  logic [FW-1:0]  wr_data
);

   logic [FW-1:0]          mem [MAX_BUCKETS];
   logic [MAX_BUCKETS-1:0] vld_ff;
   logic [MAX_BUCKETS-1:0] vld_in;
   logic [FW-1:0]          raw_ff;
   logic                   hit_ff;

   // Mark a bucket valid once written
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Count store with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_ff <= mem[rd_addr];
         hit_ff <= vld_ff[rd_addr];
      end
   end

   // Unwritten bucket reads as empty
   assign rd_data = hit_ff ? raw_ff : '0;

`ifndef SYNTH
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_data != '0) && (wr_data <= FW'(BUCKET_SIZE)))
      else $error("fill count written out of range");
`endif

endmodule

// ===== rtl/xdrt_topk.sv =====
// Closest-entry selector: a sorted row of lanes that keeps the nearest
// entries to a target, one insertion per cycle. Depends on xdrt_pkg.
module xdrt_topk #(
   parameter int BUCKET_SIZE = xdrt_pkg::BUCKET_SIZE_DEF,
   localparam int PW = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1,
   localparam int FW = $clog2(BUCKET_SIZE + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  xdrt_pkg::topk_ctl_type       ctl,
   input  logic [xdrt_pkg::ID_W-1:0]    target,
   input  logic [xdrt_pkg::ENTRY_W-1:0] in_data,
   input  logic [PW-1:0]                sel,
   output logic [xdrt_pkg::ENTRY_W-1:0] sel_data,
   output logic [FW-1:0]                count
);

   localparam int ID_W    = xdrt_pkg::ID_W;
   localparam int ENTRY_W = xdrt_pkg::ENTRY_W;

   logic [ID_W-1:0]        key_ff [BUCKET_SIZE];
   logic [ID_W-1:0]        key_in [BUCKET_SIZE];
   logic [ENTRY_W-1:0]     dat_ff [BUCKET_SIZE];
   logic [ENTRY_W-1:0]     dat_in [BUCKET_SIZE];
   logic [BUCKET_SIZE-1:0] vld_ff;
   logic [BUCKET_SIZE-1:0] vld_in;
   logic [BUCKET_SIZE-1:0] place;
   logic [ID_W-1:0]        new_key;

   // Byte 0 is the most significant byte of the distance
   function automatic logic [ID_W-1:0] dist_key(input logic [ID_W-1:0] x);
      logic [ID_W-1:0] k;
      for (int j = 0; j < ID_W / 8; j++) begin
         k[8*(ID_W/8 - 1 - j) +: 8] = x[8*j +: 8];
      end
      return k;
   endfunction

   assign new_key = dist_key(in_data[ENTRY_W-1 -: ID_W] ^ target);

   // The new entry takes the first strictly farther or empty lane; the lanes behind it shift back
   always_comb begin
      for (int r = 0; r < BUCKET_SIZE; r++) begin
         place[r] = !vld_ff[r] || (new_key < key_ff[r]);
      end
      key_in[0] = place[0] ? new_key : key_ff[0];
      dat_in[0] = place[0] ? in_data : dat_ff[0];
      vld_in[0] = 1'b1;
      for (int r = 1; r < BUCKET_SIZE; r++) begin
         if (place[r] && !place[r-1]) begin
            key_in[r] = new_key;
            dat_in[r] = in_data;
         end else if (place[r]) begin
            key_in[r] = key_ff[r-1];
            dat_in[r] = dat_ff[r-1];
         end else begin
            key_in[r] = key_ff[r];
            dat_in[r] = dat_ff[r];
         end
         vld_in[r] = vld_ff[r] | vld_ff[r-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.push) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         for (int r = 0; r < BUCKET_SIZE; r++) begin
            key_ff[r] <= key_in[r];
            dat_ff[r] <= dat_in[r];
         end
      end
   end

   assign sel_data = dat_ff[sel];
   assign count    = FW'($countones(vld_ff));

`ifndef SYNTH
   a_lane_prefix: assert property (@(posedge clock) disable iff (reset)
      (vld_ff & (vld_ff + BUCKET_SIZE'(1))) == '0)
      else $error("selector lanes not filled from the front");
`endif

endmodule

// ===== rtl/xdrt_engine.sv =====
// Bucket index search unit of the routing table: counts the leading set
// distance bits one per cycle. Depends on xdrt_pkg.
module xdrt_engine #(
   parameter int MAX_BUCKETS = xdrt_pkg::MAX_BUCKETS_DEF,
   localparam int CW = $clog2(MAX_BUCKETS + 1)
) (
   input  logic                   clock,
   input  logic                   start,
   input  logic [MAX_BUCKETS-1:0] dist_bits,
   input  logic [CW-1:0]          limit,
   output logic                   busy,
   output logic [CW-1:0]          count
);

   localparam int BIW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

   logic [MAX_BUCKETS-1:0] dist_ff;
   logic [CW-1:0]          cnt_ff;
   logic [CW-1:0]          cnt_in;

   // Count set distance bits from bit 0, one bit a cycle, up to the limit
   assign busy = (cnt_ff < limit) && dist_ff[cnt_ff[BIW-1:0]];

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dist_ff <= dist_bits;
      end
      cnt_ff <= cnt_in;
   end

   assign count = cnt_ff;

endmodule

// ===== rtl/xor_distance_routing_table.sv =====
// XOR-distance routing table: k-buckets of node identifiers with endpoints.
// An insert is accepted, then the bucket index search counts the leading set
// distance bits (at most the open bucket count), the bucket fill is read, the
// entries of the chosen bucket are scanned and moved as needed, the saved entry
// is written and the result is loaded. A query reads the fill of every open
// bucket and then every stored entry, one per cycle on the entry memory read
// port, and then sends its results. A held result stalls the block, once it has
// a new result to load, until the receiver takes it. Depends on xdrt_pkg,
// xdrt_req_if, xdrt_rsp_if and the submodules.
module xor_distance_routing_table #(
   parameter int BUCKET_SIZE = xdrt_pkg::BUCKET_SIZE_DEF,
   parameter int MAX_BUCKETS = xdrt_pkg::MAX_BUCKETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   xdrt_req_if.sink                      req_chan,
   xdrt_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [xdrt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata
);

   localparam int ID_W    = xdrt_pkg::ID_W;
   localparam int EP_W    = xdrt_pkg::EP_W;
   localparam int ENTRY_W = xdrt_pkg::ENTRY_W;
   localparam int EC      = MAX_BUCKETS * BUCKET_SIZE;
   localparam int EAW     = (EC > 1) ? $clog2(EC) : 1;
   localparam int BIW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int CW      = $clog2(MAX_BUCKETS + 1);
   localparam int FW      = $clog2(BUCKET_SIZE + 1);
   localparam int PW      = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;

   xdrt_pkg::state_type       state_ff, state_in;
   xdrt_pkg::result_kind_type kind_ff, kind_in;

   logic [ID_W-1:0]    own_id_ff, own_id_in;
   logic [ENTRY_W-1:0] nd_ff, nd_in;
   logic               alive_ff, alive_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [BIW-1:0]     bkt_ff, bkt_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [FW-1:0]      pos_ff, pos_in;
   logic [ENTRY_W-1:0] save_ff, save_in;
   logic               pend_ff, pend_in;

   logic               rv_ff, rv_in;
   logic [2:0]         rk_ff, rk_in;
   logic [7:0]         rb_ff, rb_in;
   logic [ID_W-1:0]    rid_ff, rid_in;
   logic [EP_W-1:0]    rep_ff, rep_in;
   logic               rl_ff, rl_in;

   logic               req_acc;
   logic               out_free;
   logic               load;
   logic [ID_W-1:0]    req_id;
   logic [ID_W-1:0]    req_dist;
   logic               srch_start;
   logic               srch_busy;
   logic [CW-1:0]      srch_cnt;
   logic [EAW-1:0]     base_a;
   logic               e_rd_en, e_wr_en;
   logic [EAW-1:0]     e_rd_addr, e_wr_addr;
   logic [ENTRY_W-1:0] e_rd_data, e_wr_data;
   logic               f_rd_en, f_wr_en;
   logic [FW-1:0]      f_rd_data, f_wr_data, f_clamp;
   logic               match;
   logic               last_bkt;
   logic               scan_last;
   xdrt_pkg::topk_ctl_type tk_ctl;
   logic [ENTRY_W-1:0] tk_data;
   logic [FW-1:0]      tk_count;

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign out_free  = !rv_ff || rsp_chan.ready;
   assign req_id    = {req_chan.id_word2, req_chan.id_word1, req_chan.id_word0};
   assign req_dist  = req_id ^ own_id_ff;
   assign base_a    = EAW'(bkt_ff) * EAW'(BUCKET_SIZE);
   assign f_clamp   = (f_rd_data > FW'(BUCKET_SIZE)) ? FW'(BUCKET_SIZE) : f_rd_data;
   assign match     = (e_rd_data == nd_ff);
   assign last_bkt  = !((CW'(bkt_ff) + CW'(1)) < cnt_ff);
   assign scan_last = !((pos_ff + FW'(1)) < fill_ff);
   assign srch_start = req_acc && (req_chan.operation == xdrt_pkg::OP_INSERT);

   // Bucket index search
   xdrt_engine #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_search (
      .clock     (clock),
      .start     (srch_start),
      .dist_bits (req_dist[MAX_BUCKETS-1:0]),
      .limit     (cnt_ff),
      .busy      (srch_busy),
      .count     (srch_cnt)
   );

   xdrt_entry_mem #(
      .DEPTH (EC),
      .AW    (EAW)
   ) u_entry_mem (
      .clock   (clock),
      .rd_en   (e_rd_en),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data)
   );

   xdrt_fill_tbl #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .BUCKET_SIZE (BUCKET_SIZE)
   ) u_fill_tbl (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (f_rd_en),
      .rd_addr (bkt_ff),
      .rd_data (f_rd_data),
      .wr_en   (f_wr_en),
      .wr_addr (bkt_ff),
      .wr_data (f_wr_data)
   );

   xdrt_topk #(
      .BUCKET_SIZE (BUCKET_SIZE)
   ) u_topk (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tk_ctl),
      .target   (nd_ff[ENTRY_W-1 -: ID_W]),
      .in_data  (e_rd_data),
      .sel      (pos_ff[PW-1:0]),
      .sel_data (tk_data),
      .count    (tk_count)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xdrt_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_chan.operation == xdrt_pkg::OP_QUERY) ?
                          xdrt_pkg::ST_Q_FILL_RD : xdrt_pkg::ST_SEARCH;
            end
         end
         xdrt_pkg::ST_SEARCH: begin
            if (!srch_busy) begin
               state_in = xdrt_pkg::ST_FILL_RD;
            end
         end
         xdrt_pkg::ST_FILL_RD:   state_in = xdrt_pkg::ST_FILL_WAIT;
         xdrt_pkg::ST_FILL_WAIT: begin
            state_in = (f_clamp == '0) ? xdrt_pkg::ST_INS_DONE : xdrt_pkg::ST_SCAN_RD;
         end
         xdrt_pkg::ST_SCAN_RD:   state_in = xdrt_pkg::ST_SCAN_CMP;
         xdrt_pkg::ST_SCAN_CMP: begin
            if (match) begin
               state_in = scan_last ? xdrt_pkg::ST_SAVE_WR : xdrt_pkg::ST_SHIFT_RD;
            end else if (!scan_last) begin
               state_in = xdrt_pkg::ST_SCAN_RD;
            end else if (fill_ff < FW'(BUCKET_SIZE)) begin
               state_in = xdrt_pkg::ST_INS_DONE;
            end else if (alive_ff) begin
               state_in = (fill_ff > FW'(1)) ? xdrt_pkg::ST_SHIFT_RD : xdrt_pkg::ST_SAVE_WR;
            end else begin
               state_in = xdrt_pkg::ST_INS_DONE;
            end
         end
         xdrt_pkg::ST_SHIFT_RD:  state_in = xdrt_pkg::ST_SHIFT_WR;
         xdrt_pkg::ST_SHIFT_WR: begin
            state_in = ((pos_ff + FW'(1)) < (fill_ff - FW'(1))) ?
                       xdrt_pkg::ST_SHIFT_RD : xdrt_pkg::ST_SAVE_WR;
         end
         xdrt_pkg::ST_SAVE_WR:   state_in = xdrt_pkg::ST_INS_DONE;
         xdrt_pkg::ST_INS_DONE: begin
            if (out_free) begin
               state_in = xdrt_pkg::ST_IDLE;
            end
         end
         xdrt_pkg::ST_Q_FILL_RD: state_in = xdrt_pkg::ST_Q_FILL_WAIT;
         xdrt_pkg::ST_Q_FILL_WAIT: begin
            if (f_clamp != '0) begin
               state_in = xdrt_pkg::ST_Q_SCAN;
            end else begin
               state_in = last_bkt ? xdrt_pkg::ST_Q_DRAIN : xdrt_pkg::ST_Q_FILL_RD;
            end
         end
         xdrt_pkg::ST_Q_SCAN: begin
            if (scan_last) begin
               state_in = last_bkt ? xdrt_pkg::ST_Q_DRAIN : xdrt_pkg::ST_Q_FILL_RD;
            end
         end
         xdrt_pkg::ST_Q_DRAIN:   state_in = xdrt_pkg::ST_EMIT;
         xdrt_pkg::ST_EMIT: begin
            if (out_free && ((tk_count == '0) || ((pos_ff + FW'(1)) == tk_count))) begin
               state_in = xdrt_pkg::ST_IDLE;
            end
         end
         default: state_in = xdrt_pkg::ST_IDLE;
      endcase
   end

   // Memory, selector and response strobes
   always_comb begin
      req_chan.ready = (state_ff == xdrt_pkg::ST_IDLE);
      e_rd_en   = 1'b0;
      e_rd_addr = base_a + EAW'(pos_ff);
      e_wr_en   = 1'b0;
      e_wr_addr = base_a;
      e_wr_data = nd_ff;
      f_rd_en   = 1'b0;
      f_wr_en   = 1'b0;
      f_wr_data = fill_ff + FW'(1);
      tk_ctl.clear = 1'b0;
      tk_ctl.push  = pend_ff;
      load      = 1'b0;
      unique case (state_ff)
         xdrt_pkg::ST_IDLE: tk_ctl.clear = 1'b1;
         xdrt_pkg::ST_FILL_RD, xdrt_pkg::ST_Q_FILL_RD: f_rd_en = 1'b1;
         xdrt_pkg::ST_FILL_WAIT: begin
            if (f_clamp == '0) begin
               e_wr_en   = 1'b1;
               f_wr_en   = 1'b1;
               f_wr_data = FW'(1);
            end
         end
         xdrt_pkg::ST_SCAN_RD, xdrt_pkg::ST_Q_SCAN: e_rd_en = 1'b1;
         xdrt_pkg::ST_SCAN_CMP: begin
            if (!match && scan_last) begin
               if (fill_ff < FW'(BUCKET_SIZE)) begin
                  e_wr_en   = 1'b1;
                  e_wr_addr = base_a + EAW'(fill_ff);
                  f_wr_en   = 1'b1;
               end else if (!alive_ff) begin
                  e_wr_en = 1'b1;
               end
            end
         end
         xdrt_pkg::ST_SHIFT_RD: begin
            e_rd_en   = 1'b1;
            e_rd_addr = base_a + EAW'(pos_ff) + EAW'(1);
         end
         xdrt_pkg::ST_SHIFT_WR: begin
            e_wr_en   = 1'b1;
            e_wr_addr = base_a + EAW'(pos_ff);
            e_wr_data = e_rd_data;
         end
         xdrt_pkg::ST_SAVE_WR: begin
            e_wr_en   = 1'b1;
            e_wr_addr = base_a + EAW'(fill_ff) - EAW'(1);
            e_wr_data = save_ff;
         end
         xdrt_pkg::ST_INS_DONE, xdrt_pkg::ST_EMIT: load = out_free;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      own_id_in = own_id_ff;
      nd_in     = nd_ff;
      alive_in  = alive_ff;
      cnt_in    = cnt_ff;
      bkt_in    = bkt_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      save_in   = save_ff;
      kind_in   = kind_ff;
      pend_in   = (state_ff == xdrt_pkg::ST_Q_SCAN);

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index)
            xdrt_pkg::CSR_OWN_ID0: own_id_in[63:0]    = csr_wdata;
            xdrt_pkg::CSR_OWN_ID1: own_id_in[127:64]  = csr_wdata;
            xdrt_pkg::CSR_OWN_ID2: own_id_in[159:128] = csr_wdata[31:0];
            default: ;
         endcase
      end

      case (state_ff)
         xdrt_pkg::ST_IDLE: begin
            if (req_acc) begin
               nd_in    = {req_id, req_chan.ip_addr, req_chan.port_num};
               alive_in = req_chan.oldest_alive;
               bkt_in   = '0;
            end
         end
         xdrt_pkg::ST_SEARCH: begin
            if (!srch_busy) begin
               // Clamp to the last bucket, open one bucket on growth
               bkt_in = (srch_cnt >= CW'(MAX_BUCKETS)) ? BIW'(MAX_BUCKETS - 1) :
                        srch_cnt[BIW-1:0];
               if ((srch_cnt >= cnt_ff) && (cnt_ff < CW'(MAX_BUCKETS))) begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         xdrt_pkg::ST_FILL_WAIT: begin
            fill_in = f_clamp;
            pos_in  = '0;
            kind_in = xdrt_pkg::KIND_APPENDED;
         end
         xdrt_pkg::ST_SCAN_CMP: begin
            if (match || (pos_ff == '0)) begin
               save_in = e_rd_data;
            end
            if (match) begin
               kind_in = xdrt_pkg::KIND_REFRESHED;
            end else if (!scan_last) begin
               pos_in = pos_ff + FW'(1);
            end else if (fill_ff < FW'(BUCKET_SIZE)) begin
               kind_in = xdrt_pkg::KIND_APPENDED;
            end else if (alive_ff) begin
               kind_in = xdrt_pkg::KIND_KEPT;
               pos_in  = '0;
            end else begin
               kind_in = xdrt_pkg::KIND_REPLACED;
            end
         end
         xdrt_pkg::ST_SHIFT_WR: pos_in = pos_ff + FW'(1);
         xdrt_pkg::ST_Q_FILL_WAIT: begin
            fill_in = f_clamp;
            pos_in  = '0;
            if ((f_clamp == '0) && !last_bkt) begin
               bkt_in = bkt_ff + BIW'(1);
            end
         end
         xdrt_pkg::ST_Q_SCAN: begin
            pos_in = pos_ff + FW'(1);
            if (scan_last && !last_bkt) begin
               bkt_in = bkt_ff + BIW'(1);
            end
         end
         xdrt_pkg::ST_Q_DRAIN: pos_in = '0;
         xdrt_pkg::ST_EMIT: begin
            if (out_free) begin
               pos_in = pos_ff + FW'(1);
            end
         end
         default: ;
      endcase
   end

   // Response register
   always_comb begin
      rv_in  = rv_ff;
      rk_in  = rk_ff;
      rb_in  = rb_ff;
      rid_in = rid_ff;
      rep_in = rep_ff;
      rl_in  = rl_ff;
      if (rv_ff && rsp_chan.ready) begin
         rv_in = 1'b0;
      end
      if (load) begin
         rv_in = 1'b1;
         if (state_ff == xdrt_pkg::ST_INS_DONE) begin
            rk_in  = kind_ff;
            rb_in  = 8'(bkt_ff);
            rid_in = nd_ff[ENTRY_W-1 -: ID_W];
            rep_in = nd_ff[EP_W-1:0];
            rl_in  = 1'b1;
         end else if (tk_count == '0) begin
            rk_in  = xdrt_pkg::KIND_NO_ENTRIES;
            rb_in  = '0;
            rid_in = '0;
            rep_in = '0;
            rl_in  = 1'b1;
         end else begin
            rk_in  = xdrt_pkg::KIND_CLOSEST;
            rb_in  = '0;
            rid_in = tk_data[ENTRY_W-1 -: ID_W];
            rep_in = tk_data[EP_W-1:0];
            rl_in  = ((pos_ff + FW'(1)) == tk_count);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= xdrt_pkg::ST_IDLE;
         own_id_ff <= '0;
         cnt_ff    <= CW'(1);
         pend_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         own_id_ff <= own_id_in;
         cnt_ff    <= cnt_in;
         pend_ff   <= pend_in;
         rv_ff     <= rv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      nd_ff    <= nd_in;
      alive_ff <= alive_in;
      bkt_ff   <= bkt_in;
      fill_ff  <= fill_in;
      pos_ff   <= pos_in;
      save_ff  <= save_in;
      kind_ff  <= kind_in;
      rk_ff    <= rk_in;
      rb_ff    <= rb_in;
      rid_ff   <= rid_in;
      rep_ff   <= rep_in;
      rl_ff    <= rl_in;
   end

   assign rsp_chan.valid        = rv_ff;
   assign rsp_chan.result_kind  = rk_ff;
   assign rsp_chan.bucket_num   = rb_ff;
   assign rsp_chan.out_id_word0 = rid_ff[63:0];
   assign rsp_chan.out_id_word1 = rid_ff[127:64];
   assign rsp_chan.out_id_word2 = rid_ff[159:128];
   assign rsp_chan.out_ip       = rep_ff[47:16];
   assign rsp_chan.out_port     = rep_ff[15:0];
   assign rsp_chan.last_flag    = rl_ff;

`ifndef SYNTH
   a_bucket_count: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= CW'(1)) && (cnt_ff <= CW'(MAX_BUCKETS)))
      else $error("open bucket count out of range");
   a_scan_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xdrt_pkg::ST_SCAN_CMP) |-> (pos_ff < fill_ff))
      else $error("bucket scan past fill");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && (rk_ff == xdrt_pkg::KIND_NO_ENTRIES)) |-> (rl_ff && (rid_ff == '0)))
      else $error("empty-table result malformed");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != xdrt_pkg::ST_IDLE) |-> !req_chan.ready)
      else $error("request taken while a transaction is in flight");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the XOR-distance routing table: directed and random
// inserts and closest-node queries, predicted by an in-bench k-bucket table.
// Depends on xdrt_pkg, xdrt_req_if, xdrt_rsp_if and xor_distance_routing_table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BSZ     = xdrt_pkg::BUCKET_SIZE_DEF;
   localparam int NBKT    = xdrt_pkg::MAX_BUCKETS_DEF;
   localparam int LIMIT   = 4000000;
   localparam int SETTLE  = 2500;

   typedef struct {
      logic        op;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [31:0] w2;
      logic [31:0] ip;
      logic [15:0] port;
      logic        alive;
   } node_req_type;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  bidx;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [31:0] w2;
      logic [31:0] ip;
      logic [15:0] port;
      logic        last;
   } node_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [xdrt_pkg::CSR_IDX_W-1:0] csr_index = xdrt_pkg::CSR_OWN_ID0;
   logic [63:0]                    csr_wdata = '0;

   xdrt_req_if req_bus ();
   xdrt_rsp_if rsp_bus ();

   xor_distance_routing_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow table
   logic [63:0] own_w0, own_w1;
   logic [31:0] own_w2;
   int          bkt_count;
   int          bkt_fill [NBKT];
   logic [63:0] ent_w0 [NBKT*BSZ];
   logic [63:0] ent_w1 [NBKT*BSZ];
   logic [31:0] ent_w2 [NBKT*BSZ];
   logic [47:0] ent_ep [NBKT*BSZ];

   node_req_type pend_q [$];
   node_req_type pool_q [$];
   node_rsp_type route_q [$];
   int        errors = 0;
   int        n_accepted = 0;
   int        n_inserts = 0;
   int        n_queries = 0;
   int        n_results = 0;
   int        kind_seen [8];
   bit        calm_tail = 1'b0;
   bit        long_hold_done = 1'b0;

   // Distance as a number: byte 0 most significant
   function automatic logic [159:0] dist_key(int e, logic [63:0] t0, logic [63:0] t1,
                                            logic [31:0] t2);
      logic [159:0] x;
      logic [159:0] k;
      x = {ent_w2[e] ^ t2, ent_w1[e] ^ t1, ent_w0[e] ^ t0};
      for (int j = 0; j < 20; j++) k[159-8*j -: 8] = x[8*j +: 8];
      return k;
   endfunction

   function automatic void rotate_newest(int base, int from, int fill);
      logic [63:0] a0, a1;
      logic [31:0] a2;
      logic [47:0] ep;
      a0 = ent_w0[base+from];
      a1 = ent_w1[base+from];
      a2 = ent_w2[base+from];
      ep = ent_ep[base+from];
      for (int p = from; p + 1 < fill; p++) begin
         ent_w0[base+p] = ent_w0[base+p+1];
         ent_w1[base+p] = ent_w1[base+p+1];
         ent_w2[base+p] = ent_w2[base+p+1];
         ent_ep[base+p] = ent_ep[base+p+1];
      end
      ent_w0[base+fill-1] = a0;
      ent_w1[base+fill-1] = a1;
      ent_w2[base+fill-1] = a2;
      ent_ep[base+fill-1] = ep;
   endfunction

   function automatic void route_insert(node_req_type r);
      logic [159:0]              d;
      logic [47:0]               ep;
      int                        idx, base, fill, hit;
      xdrt_pkg::result_kind_type k;
      node_rsp_type              o;
      d = {r.w2 ^ own_w2, r.w1 ^ own_w1, r.w0 ^ own_w0};
      ep = {r.ip, r.port};
      idx = 0;
      while (idx < bkt_count && idx < NBKT && d[idx]) idx++;
      if (idx >= bkt_count) begin
         if (bkt_count < NBKT) bkt_count++;
         if (idx >= NBKT) idx = NBKT - 1;
      end
      base = idx * BSZ;
      fill = bkt_fill[idx];
      hit = -1;
      for (int p = 0; p < fill; p++)
         if (hit < 0 && ent_w0[base+p] == r.w0 && ent_w1[base+p] == r.w1 &&
             ent_w2[base+p] == r.w2 && ent_ep[base+p] == ep)
            hit = p;
      if (hit >= 0) begin
         rotate_newest(base, hit, fill);
         k = xdrt_pkg::KIND_REFRESHED;
      end else if (fill < BSZ) begin
         ent_w0[base+fill] = r.w0;
         ent_w1[base+fill] = r.w1;
         ent_w2[base+fill] = r.w2;
         ent_ep[base+fill] = ep;
         bkt_fill[idx] = fill + 1;
         k = xdrt_pkg::KIND_APPENDED;
      end else if (r.alive) begin
         rotate_newest(base, 0, fill);
         k = xdrt_pkg::KIND_KEPT;
      end else begin
         ent_w0[base] = r.w0;
         ent_w1[base] = r.w1;
         ent_w2[base] = r.w2;
         ent_ep[base] = ep;
         k = xdrt_pkg::KIND_REPLACED;
      end
      o = '{k, idx[7:0], r.w0, r.w1, r.w2, r.ip, r.port, 1'b1};
      route_q.insert(route_q.size(), o);
   endfunction

   function automatic void route_query(node_req_type r);
      int           sel [BSZ];
      int           n, pos, e;
      node_rsp_type o;
      n = 0;
      for (int b = 0; b < bkt_count; b++)
         for (int p = 0; p < bkt_fill[b]; p++) begin
            e = b * BSZ + p;
            pos = n;
            while (pos > 0 && dist_key(e, r.w0, r.w1, r.w2) <
                              dist_key(sel[pos-1], r.w0, r.w1, r.w2))
               pos--;
            if (pos >= BSZ) continue;
            if (n < BSZ) n++;
            for (int q = n - 1; q > pos; q--) sel[q] = sel[q-1];
            sel[pos] = e;
         end
      if (n == 0) begin
         o = '{xdrt_pkg::KIND_NO_ENTRIES, 8'd0, 64'd0, 64'd0, 32'd0, 32'd0, 16'd0, 1'b1};
         route_q.insert(route_q.size(), o);
      end
      for (int q = 0; q < n; q++) begin
         e = sel[q];
         o = '{xdrt_pkg::KIND_CLOSEST, 8'd0, ent_w0[e], ent_w1[e], ent_w2[e],
               ent_ep[e][47:16], ent_ep[e][15:0], (q + 1 == n)};
         route_q.insert(route_q.size(), o);
      end
   endfunction

   // Node whose distance to the own identifier starts with n set bits
   function automatic node_req_type mk_insert(int n, logic alive);
      node_req_type r;
      logic [159:0] d;
      d = {$urandom, $urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < 160; i++) if (i < n) d[i] = 1'b1;
      if (n < 160) d[n] = 1'b0;
      r.op = xdrt_pkg::OP_INSERT;
      r.w0 = d[63:0] ^ own_w0;
      r.w1 = d[127:64] ^ own_w1;
      r.w2 = d[159:128] ^ own_w2;
      r.ip = $urandom;
      r.port = 16'($urandom);
      r.alive = alive;
      return r;
   endfunction

   function automatic node_req_type mk_query(logic [63:0] t0, logic [63:0] t1,
                                             logic [31:0] t2);
      node_req_type r;
      r = '{xdrt_pkg::OP_QUERY, t0, t1, t2, $urandom, 16'($urandom),
            1'($urandom_range(0, 1))};
      return r;
   endfunction

   function automatic void add_insert(node_req_type r);
      pend_q.insert(pend_q.size(), r);
      pool_q.insert(pool_q.size(), r);
   endfunction

   function automatic void add_item(node_req_type r);
      pend_q.insert(pend_q.size(), r);
   endfunction

   // Drive requests, predict every accepted transaction
   int  tx_gap = 0;
   bit  tx_busy;
   always @(posedge clock) begin
      tx_busy = req_bus.valid;
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (pend_q[0].op == xdrt_pkg::OP_INSERT) begin
            route_insert(pend_q[0]);
            n_inserts++;
         end else begin
            route_query(pend_q[0]);
            n_queries++;
         end
         void'(pend_q.pop_front());
         n_accepted++;
         tx_busy = 1'b0;
      end
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (tx_busy) begin
         req_bus.valid <= 1'b1;
      end else if (tx_gap > 0) begin
         tx_gap--;
         req_bus.valid <= 1'b0;
      end else if (pend_q.size() != 0 && !calm_tail && $urandom_range(0, 5) == 0) begin
         tx_gap = $urandom_range(0, 2);
         req_bus.valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
         req_bus.valid        <= 1'b1;
         req_bus.operation    <= pend_q[0].op;
         req_bus.id_word0     <= pend_q[0].w0;
         req_bus.id_word1     <= pend_q[0].w1;
         req_bus.id_word2     <= pend_q[0].w2;
         req_bus.ip_addr      <= pend_q[0].ip;
         req_bus.port_num     <= pend_q[0].port;
         req_bus.oldest_alive <= pend_q[0].alive;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name, want, got);
         errors++;
      end
   endfunction

   // Accept results with random back-pressure, compare against the oldest expectation
   int           rx_gap = 0;
   int           rx_hold = 0;
   node_rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_results++;
         kind_seen[rsp_bus.result_kind]++;
         if (route_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d", $realtime,
                     rsp_bus.result_kind);
            errors++;
         end else begin
            want = route_q.pop_front();
            check_field("result_kind", 64'(want.kind), 64'(rsp_bus.result_kind));
            check_field("bucket_num", 64'(want.bidx), 64'(rsp_bus.bucket_num));
            check_field("out_id_word0", want.w0, rsp_bus.out_id_word0);
            check_field("out_id_word1", want.w1, rsp_bus.out_id_word1);
            check_field("out_id_word2", 64'(want.w2), 64'(rsp_bus.out_id_word2));
            check_field("out_ip", 64'(want.ip), 64'(rsp_bus.out_ip));
            check_field("out_port", 64'(want.port), 64'(rsp_bus.out_port));
            check_field("last_flag", 64'(want.last), 64'(rsp_bus.last_flag));
         end
      end
      // hold off for a long stretch once, while requests keep coming
      if (!long_hold_done && n_accepted == 70) begin
         long_hold_done <= 1'b1;
         rx_hold = 6000;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold--;
         rsp_bus.ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
         rx_gap = $urandom_range(0, 2);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog
   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(xdrt_pkg::csr_index_type idx, logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         xdrt_pkg::CSR_OWN_ID0: own_w0 = data;
         xdrt_pkg::CSR_OWN_ID1: own_w1 = data;
         default:               own_w2 = data[31:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pend_q.size() != 0 || route_q.size() != 0 || req_bus.valid) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_own(logic [63:0] a, logic [63:0] b, logic [31:0] c);
      csr_write(xdrt_pkg::CSR_OWN_ID0, a);
      csr_write(xdrt_pkg::CSR_OWN_ID1, b);
      csr_write(xdrt_pkg::CSR_OWN_ID2, {32'd0, c});
   endtask

   task automatic random_phase(int count);
      node_req_type r;
      int           n;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 1) && pool_q.size() != 0) begin
               r = pool_q[$urandom_range(0, pool_q.size() - 1)];
               add_item(mk_query(r.w0 ^ 64'($urandom_range(0, 255)), r.w1, r.w2));
            end else begin
               add_item(mk_query({$urandom, $urandom}, {$urandom, $urandom}, $urandom));
            end
         end else if ($urandom_range(0, 3) == 0 && pool_q.size() != 0) begin
            // refresh a known node, with a fresh ping answer
            r = pool_q[$urandom_range(0, pool_q.size() - 1)];
            r.alive = 1'($urandom_range(0, 1));
            add_item(r);
         end else begin
            n = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 170);
            add_insert(mk_insert(n, 1'($urandom_range(0, 1))));
         end
      end
   endtask

   node_req_type keep_node;
   node_req_type twin;
   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = xdrt_pkg::OP_INSERT;
      req_bus.id_word0 = '0;
      req_bus.id_word1 = '0;
      req_bus.id_word2 = '0;
      req_bus.ip_addr = '0;
      req_bus.port_num = '0;
      req_bus.oldest_alive = 1'b0;
      rsp_bus.ready = 1'b0;
      own_w0 = '0;
      own_w1 = '0;
      own_w2 = '0;
      bkt_count = 1;
      foreach (bkt_fill[i]) bkt_fill[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: own id all zero
      set_own(64'd0, 64'd0, 32'd0);
      add_item(mk_query('0, '0, '0));
      add_insert('{xdrt_pkg::OP_INSERT, 64'd0, 64'd0, 32'd0, 32'd0, 16'd0, 1'b0});
      add_insert('{xdrt_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1, '1, '1, 1'b1});
      for (int i = 0; i < 5; i++) add_insert(mk_insert(0, 1'b0));
      keep_node = mk_insert(0, 1'b1);
      add_insert(keep_node);
      add_insert(mk_insert(0, 1'b1));          // full bucket, oldest alive
      add_insert(mk_insert(0, 1'b0));          // full bucket, oldest dead
      add_item(keep_node);                     // refresh
      twin = keep_node;
      twin.port = ~keep_node.port;              // same id, other port: not equal
      add_item(twin);
      add_insert(mk_insert(1, 1'b0));          // opens bucket 1
      twin = mk_insert(1, 1'b0);
      add_insert(twin);
      twin.ip = ~twin.ip;                       // equal distance, tie in query
      add_insert(twin);
      add_insert(mk_insert(5, 1'b0));          // index capped by bucket count
      add_insert(mk_insert(160, 1'b0));        // all distance bits set
      add_item(mk_query('0, '0, '0));
      add_item(mk_query('1, '1, '1));
      add_item(mk_query(twin.w0, twin.w1, twin.w2));
      add_item(mk_query({$urandom, $urandom}, {$urandom, $urandom}, $urandom));
      wait_idle();

      // Random with own id all ones
      set_own('1, '1, '1);
      random_phase(60);
      wait_idle();

      // Random own id, quiet handshakes at the end
      set_own({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      random_phase(55);
      while (pend_q.size() != 0) @(posedge clock);
      calm_tail = 1'b1;
      random_phase(25);
      wait_idle();

      $display("Covered %0d inserts and %0d queries, %0d results, buckets open: %0d",
               n_inserts, n_queries, n_results, bkt_count);
      $display("Kinds: refreshed %0d appended %0d kept %0d replaced %0d closest %0d empty %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
               kind_seen[5]);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ===== xor_distance_routing_table.f =====
rtl/xdrt_pkg.sv
rtl/xdrt_req_if.sv
rtl/xdrt_rsp_if.sv
rtl/xdrt_entry_mem.sv
rtl/xdrt_fill_tbl.sv
rtl/xdrt_topk.sv
rtl/xdrt_engine.sv
rtl/xor_distance_routing_table.sv
dv/tb.sv
